@@ design/command_coalesce_rr_mailbox_top_macros.svh @@
// assertion macros for the command coalescer mailbox
`ifndef COMMAND_COALESCE_RR_MAILBOX_TOP_MACROS_SVH
`define COMMAND_COALESCE_RR_MAILBOX_TOP_MACROS_SVH
`ifndef SYNTH
`define CCRM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define CCRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define CCRM_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define CCRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/ccrm_pkg.sv @@
// shared constants, types and forward id table for the command coalescer
`timescale 1ns / 1ps
package ccrm_pkg;
	localparam int unsigned KNOWN_IDS = 7;
	localparam int unsigned NUM_SLOTS_DEF = 7;
	localparam int unsigned ID_W = 11;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned DIV_W = 8;
	localparam int unsigned CTRL_W = 10;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 11;

	localparam logic [ID_W-1:0] TRIGGER_ID_RST = 11'h7F0;
	localparam logic [DIV_W-1:0] BUS_DIVIDER_RST = 8'd4;

	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_ID = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUS_DIVIDER = 2'd1;

	typedef struct packed {
		logic hit;
		logic [ID_W-1:0] id;
		logic toggle;
		logic trig;
	} item_res_t;

	function automatic logic [ID_W-1:0] fwd_id(input int unsigned i);
		logic [ID_W-1:0] r;
		unique case (i)
			0: r = 11'h150;
			1: r = 11'h151;
			2: r = 11'h155;
			3: r = 11'h156;
			4: r = 11'h157;
			5: r = 11'h471;
			6: r = 11'h159;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage

@@ design/ccrm_slot_mem.sv @@
// slot data memory, one write and one registered read port
`timescale 1ns / 1ps
module ccrm_slot_mem #(
	parameter int unsigned DEPTH = ccrm_pkg::NUM_SLOTS_DEF,
	parameter int unsigned AW = 3,
	parameter int unsigned W = 64
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

@@ design/ccrm_ctrl.sv @@
// dirty flags, rotating drain select, toggle and soft trigger state
`timescale 1ns / 1ps
`include "command_coalesce_rr_mailbox_top_macros.svh"
module ccrm_ctrl #(
	parameter int unsigned NUM_SLOTS = ccrm_pkg::NUM_SLOTS_DEF,
	parameter int unsigned IW = 3
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic                        func,
	input  logic [ccrm_pkg::ID_W-1:0]   frame_id,
	input  logic                        lo_byte_nz,
	input  logic [ccrm_pkg::ID_W-1:0]   trigger_id,
	output logic                        wr_en,
	output logic [IW-1:0]               wr_addr,
	output logic                        rd_en,
	output logic [IW-1:0]               rd_addr,
	output ccrm_pkg::item_res_t         res
);
	logic [NUM_SLOTS-1:0] dirty_q;
	logic [IW-1:0] scan_q;
	logic toggle_q;
	logic trig_q;

	logic wr_hit;
	logic [IW-1:0] wr_idx;
	logic sel_hit;
	logic [IW-1:0] sel_idx;
	logic [IW-1:0] scan_nxt;
	logic is_trig;
	logic frame;
	logic tick;
	logic drain;

	always_comb begin
		wr_hit = 1'b0;
		wr_idx = '0;
		for (int unsigned i = 0; i < NUM_SLOTS; i++) begin
			if (i < ccrm_pkg::KNOWN_IDS && ccrm_pkg::fwd_id(i) == frame_id) begin
				wr_hit = 1'b1;
				wr_idx = IW'(i);
			end
		end
	end

	// lowest distance from the scan pointer wins
	always_comb begin
		logic [IW:0] pos;
		sel_hit = 1'b0;
		sel_idx = '0;
		for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
			pos = {1'b0, scan_q} + (IW+1)'(k);
			if (pos >= (IW+1)'(NUM_SLOTS)) begin
				pos = pos - (IW+1)'(NUM_SLOTS);
			end
			if (dirty_q[pos[IW-1:0]]) begin
				sel_hit = 1'b1;
				sel_idx = pos[IW-1:0];
			end
		end
	end

	assign scan_nxt = (sel_idx == IW'(NUM_SLOTS - 1)) ? '0 : sel_idx + IW'(1);
	assign is_trig = (frame_id == trigger_id);
	assign frame = accept && !func;
	assign tick = accept && func;
	assign drain = tick && sel_hit;

	assign wr_en = frame && !is_trig && wr_hit;
	assign wr_addr = wr_idx;
	assign rd_en = drain;
	assign rd_addr = sel_idx;

	always_comb begin
		res.hit = drain;
		res.id = drain ? ccrm_pkg::fwd_id(int'(sel_idx)) : '0;
		res.toggle = toggle_q ^ drain;
		res.trig = (frame && is_trig) ? lo_byte_nz : trig_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= '0;
			scan_q <= '0;
			toggle_q <= 1'b0;
			trig_q <= 1'b0;
		end else begin
			if (wr_en) begin
				dirty_q[wr_idx] <= 1'b1;
			end
			if (drain) begin
				dirty_q[sel_idx] <= 1'b0;
				scan_q <= scan_nxt;
				toggle_q <= ~toggle_q;
			end
			if (frame && is_trig) begin
				trig_q <= lo_byte_nz;
			end
		end
	end

	`CCRM_ASSERT_SAME(a_scan_range, clk, arst_n, 1'b1, scan_q <= IW'(NUM_SLOTS - 1))
	`CCRM_ASSERT_SAME(a_empty_miss, clk, arst_n, tick && !sel_hit, dirty_q == '0)
	`CCRM_ASSERT_NEXT(a_drain_flip, clk, arst_n, drain, toggle_q != $past(toggle_q))
	`CCRM_ASSERT_NEXT(a_frame_keeps, clk, arst_n, frame, $stable(scan_q) && $stable(toggle_q))
	`CCRM_ASSERT_SAME(a_no_rw_clash, clk, arst_n, wr_en, !rd_en)
endmodule

@@ design/command_coalesce_rr_mailbox_top.sv @@
// top level of the latest-value command coalescer with round-robin mailbox
`timescale 1ns / 1ps
// usage
// - command channel: start with func, frame_id, data_low, data_high; a request is
//   taken at a clock edge with start high and busy low; busy stays low, so a
//   request may be issued every cycle
// - func low stores a frame into its forward slot or updates the soft trigger;
//   func high drains the next dirty slot at or after the rotating scan pointer
// - every request gives one result, marked by done, in the cycle after it is taken;
//   the slot data comes from the slot memory read issued at the accepting edge
// - throughput is one request per cycle; the slot memory read is registered,
//   and a write followed by a read of the same slot is ordered across edges,
//   so no interlock is needed
// - config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0 is
//   the trigger id, index 1 the bus divider, other indexes are dropped; write
//   only while no request is in flight
// - reset clears dirty flags, scan pointer, toggle and soft trigger and loads the
//   register defaults; slot data is undefined until written
// - results cannot be held off: the receiver must take each done cycle
module command_coalesce_rr_mailbox_top #(
	parameter int unsigned NUM_SLOTS = ccrm_pkg::NUM_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             func,
	input  logic [ccrm_pkg::ID_W-1:0]        frame_id,
	input  logic [ccrm_pkg::DATA_W-1:0]      data_low,
	input  logic [ccrm_pkg::DATA_W-1:0]      data_high,
	output logic                             done,
	output logic                             mail_valid,
	output logic [ccrm_pkg::ID_W-1:0]        mail_id,
	output logic [ccrm_pkg::DATA_W-1:0]      mail_low,
	output logic [ccrm_pkg::DATA_W-1:0]      mail_high,
	output logic                             mail_toggle,
	output logic [ccrm_pkg::CTRL_W-1:0]      control_word,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ccrm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ccrm_pkg::CFG_DATA_W-1:0]  cfg_data
);
	localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int unsigned MW = 2 * ccrm_pkg::DATA_W;

	logic [ccrm_pkg::ID_W-1:0] trig_q;
	logic [ccrm_pkg::DIV_W-1:0] div_q;

	logic accept;
	logic wr_en;
	logic rd_en;
	logic [IW-1:0] wr_addr;
	logic [IW-1:0] rd_addr;
	logic [MW-1:0] rdata;
	ccrm_pkg::item_res_t res;

	logic done_s1;
	logic valid_s1;
	logic [ccrm_pkg::ID_W-1:0] id_s1;
	logic toggle_s1;
	logic [ccrm_pkg::CTRL_W-1:0] ctrl_s1;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q <= ccrm_pkg::TRIGGER_ID_RST;
			div_q <= ccrm_pkg::BUS_DIVIDER_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == ccrm_pkg::REG_TRIGGER_ID) begin
				trig_q <= cfg_data;
			end else if (cfg_index == ccrm_pkg::REG_BUS_DIVIDER) begin
				div_q <= cfg_data[ccrm_pkg::DIV_W-1:0];
			end
		end
	end

	ccrm_ctrl #(
		.NUM_SLOTS(NUM_SLOTS),
		.IW(IW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.func(func),
		.frame_id(frame_id),
		.lo_byte_nz(data_low[7:0] != 8'd0),
		.trigger_id(trig_q),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.res(res)
	);

	ccrm_slot_mem #(
		.DEPTH(NUM_SLOTS),
		.AW(IW),
		.W(MW)
	) u_mem (
		.clk(clk),
		.we(wr_en),
		.waddr(wr_addr),
		.wdata({data_high, data_low}),
		.re(rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
			valid_s1 <= accept && res.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_s1 <= res.id;
			toggle_s1 <= res.toggle;
			ctrl_s1 <= {res.trig, 1'b1, div_q};
		end
	end

	assign done = done_s1;
	assign mail_valid = valid_s1;
	assign mail_id = valid_s1 ? id_s1 : '0;
	assign mail_low = valid_s1 ? rdata[ccrm_pkg::DATA_W-1:0] : '0;
	assign mail_high = valid_s1 ? rdata[MW-1:ccrm_pkg::DATA_W] : '0;
	assign mail_toggle = toggle_s1;
	assign control_word = ctrl_s1;
endmodule
